FILE: hw/rtl/spdb_pkg.sv
package spdb_pkg;

    localparam int AXES        = 3;
    localparam int DW          = 32;
    localparam int FRAC        = 16;
    localparam int DIFF_W      = DW + 1;
    localparam int SQ_W        = 2 * DW;
    localparam int Q_W         = SQ_W + 2;
    localparam int ROOT_W      = Q_W / 2;
    localparam int REM_W       = ROOT_W + 3;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int QUO_W       = FRAC + 1;
    localparam int DIV_STAGES  = QUO_W;
    localparam int U_W         = QUO_W + 1;
    localparam int CFG_W       = 31;
    localparam int IDX_W       = 3;
    localparam int LIMIT_W     = 2 * CFG_W - FRAC;

    typedef enum logic [IDX_W-1:0] {
        REG_STIFFNESS    = 3'd0,
        REG_DAMPING      = 3'd1,
        REG_REST_LENGTH  = 3'd2,
        REG_BREAK_FACTOR = 3'd3,
        REG_LIMITED_MODE = 3'd4
    } cfg_reg_t;

    typedef logic [DIFF_W-1:0] diff_t;

    typedef struct packed {
        diff_t [AXES-1:0] r;
        diff_t [AXES-1:0] v;
    } bond_vec_t;

    typedef struct packed {
        bond_vec_t         vec;
        logic [ROOT_W-1:0] len;
    } div_side_t;

    typedef struct packed {
        logic [CFG_W-1:0]   stiffness;
        logic [CFG_W-1:0]   damping;
        logic [CFG_W-1:0]   rest_length;
        logic               limited_mode;
        logic [LIMIT_W-1:0] limit;
    } force_cfg_t;

endpackage

FILE: hw/rtl/spdb_if.sv
interface spdb_in_if import spdb_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [DW-1:0] pos_a_x;
    logic [DW-1:0] pos_a_y;
    logic [DW-1:0] pos_a_z;
    logic [DW-1:0] pos_b_x;
    logic [DW-1:0] pos_b_y;
    logic [DW-1:0] pos_b_z;
    logic [DW-1:0] vel_a_x;
    logic [DW-1:0] vel_a_y;
    logic [DW-1:0] vel_a_z;
    logic [DW-1:0] vel_b_x;
    logic [DW-1:0] vel_b_y;
    logic [DW-1:0] vel_b_z;

    modport source (
        output valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
               vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
        input  ready
    );
    modport sink (
        input  valid, pos_a_x, pos_a_y, pos_a_z, pos_b_x, pos_b_y, pos_b_z,
               vel_a_x, vel_a_y, vel_a_z, vel_b_x, vel_b_y, vel_b_z,
        output ready
    );
endinterface

interface spdb_out_if import spdb_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [DW-1:0] force_x;
    logic [DW-1:0] force_y;
    logic [DW-1:0] force_z;
    logic          broken;

    modport source (output valid, force_x, force_y, force_z, broken, input ready);
    modport sink (input valid, force_x, force_y, force_z, broken, output ready);
endinterface

FILE: hw/rtl/spdb_sqrt.sv
module spdb_sqrt import spdb_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_vld,
    input  logic [Q_W-1:0]    in_sq,
    input  bond_vec_t         in_vec,
    output logic              out_vld,
    output logic [ROOT_W-1:0] out_root,
    output bond_vec_t         out_vec
);

    logic              vld_reg  [SQRT_STAGES];
    logic [REM_W-1:0]  rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];
    logic [Q_W-1:0]    q_reg    [SQRT_STAGES];
    bond_vec_t         vec_reg  [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
        logic              vld_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [ROOT_W-1:0] root_prev;
        logic [Q_W-1:0]    q_prev;
        bond_vec_t         vec_prev;
        logic [REM_W-1:0]  rem_sh;
        logic [REM_W-1:0]  trial;
        logic              take;
        logic [REM_W-1:0]  rem_next;
        logic [ROOT_W-1:0] root_next;

        if (k == 0) begin : g_first
            assign vld_prev  = in_vld;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign q_prev    = in_sq;
            assign vec_prev  = in_vec;
        end else begin : g_next
            assign vld_prev  = vld_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign q_prev    = q_reg[k-1];
            assign vec_prev  = vec_reg[k-1];
        end

        assign rem_sh    = {rem_prev[REM_W-3:0], q_prev[Q_W-1 -: 2]};
        assign trial     = {{(REM_W-ROOT_W-2){1'b0}}, root_prev, 2'b01};
        assign take      = rem_sh >= trial;
        assign rem_next  = take ? rem_sh - trial : rem_sh;
        assign root_next = {root_prev[ROOT_W-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                root_reg[k] <= root_next;
                q_reg[k]    <= {q_prev[Q_W-3:0], 2'b00};
                vec_reg[k]  <= vec_prev;
            end
        end
    end

    assign out_vld  = vld_reg[SQRT_STAGES-1];
    assign out_root = root_reg[SQRT_STAGES-1];
    assign out_vec  = vec_reg[SQRT_STAGES-1];

endmodule

FILE: hw/rtl/spdb_div.sv
module spdb_div import spdb_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_vld,
    input  logic [AXES-1:0][DW-1:0]     in_mag,
    input  div_side_t                   in_side,
    output logic                        out_vld,
    output logic [AXES-1:0][QUO_W-1:0]  out_quo,
    output div_side_t                   out_side
);

    logic                                vld_reg  [DIV_STAGES];
    logic [AXES-1:0][ROOT_W-1:0]         rem_reg  [DIV_STAGES];
    logic [AXES-1:0][QUO_W-1:0]          quo_reg  [DIV_STAGES];
    div_side_t                           side_reg [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic                        vld_prev;
        div_side_t                   side_prev;
        logic [AXES-1:0][ROOT_W-1:0] rem_prev;
        logic [AXES-1:0][QUO_W-1:0]  quo_prev;
        logic [AXES-1:0]             nbit;
        logic [AXES-1:0][ROOT_W-1:0] rem_next;
        logic [AXES-1:0][QUO_W-1:0]  quo_next;

        if (k == 0) begin : g_first
            assign vld_prev  = in_vld;
            assign side_prev = in_side;
            for (genvar a = 0; a < AXES; a++) begin : g_lane
                assign rem_prev[a] = {{(ROOT_W-DW+1){1'b0}}, in_mag[a][DW-1:1]};
                assign quo_prev[a] = '0;
                assign nbit[a]     = in_mag[a][0];
            end
        end else begin : g_next
            assign vld_prev  = vld_reg[k-1];
            assign side_prev = side_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign quo_prev  = quo_reg[k-1];
            assign nbit      = '0;
        end

        for (genvar a = 0; a < AXES; a++) begin : g_calc
            logic [ROOT_W:0] sh;
            logic [ROOT_W:0] dvs;
            logic [ROOT_W:0] diff;
            logic            ge;

            assign sh          = {rem_prev[a], nbit[a]};
            assign dvs         = {1'b0, side_prev.len};
            assign ge          = sh >= dvs;
            assign diff        = sh - dvs;
            assign rem_next[a] = ge ? diff[ROOT_W-1:0] : sh[ROOT_W-1:0];
            assign quo_next[a] = {quo_prev[a][QUO_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= rem_next;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign out_vld  = vld_reg[DIV_STAGES-1];
    assign out_quo  = quo_reg[DIV_STAGES-1];
    assign out_side = side_reg[DIV_STAGES-1];

endmodule

FILE: hw/rtl/spdb_force.sv
module spdb_force import spdb_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  force_cfg_t                 cfg,
    input  logic                       in_vld,
    input  logic [AXES-1:0][QUO_W-1:0] in_quo,
    input  div_side_t                  in_side,
    output logic                       out_vld,
    output logic [AXES-1:0][DW-1:0]    out_force,
    output logic                       out_broken
);

    localparam int EP_W  = CFG_W + QUO_W;
    localparam int VU_W  = DIFF_W + U_W;
    localparam int D_W   = DIFF_W + 2;
    localparam int DOT_W = VU_W + 2;
    localparam int S_W   = DOT_W - FRAC;
    localparam int KH_W  = CFG_W + D_W - 1 - FRAC;
    localparam int KL_W  = CFG_W + FRAC;
    localparam int EL_W  = KH_W + 1;
    localparam int PP_W  = S_W + QUO_W;
    localparam int PM_W  = PP_W - FRAC;
    localparam int DH_W  = CFG_W + PM_W - FRAC;
    localparam int DM_W  = DH_W + 1;
    localparam int SUM_W = DM_W + 1;

    // Stage 0: unit vector, rest-length and velocity products.
    logic                       vld0_reg;
    logic [AXES-1:0][DIFF_W-1:0] r0_reg;
    logic [AXES-1:0][QUO_W-1:0] umag0_reg;
    logic [AXES-1:0]            usgn0_reg;
    logic [AXES-1:0][EP_W-1:0]  ep0_reg;
    logic [AXES-1:0][VU_W-1:0]  vu0_reg;
    logic                       brk0_reg;

    logic [AXES-1:0][QUO_W-1:0] umag0_next;
    logic [AXES-1:0]            usgn0_next;
    logic [AXES-1:0][EP_W-1:0]  ep0_next;
    logic [AXES-1:0][VU_W-1:0]  vu0_next;
    logic                       brk0_next;

    always_comb
    begin
        logic [U_W-1:0] u;
        for (int i = 0; i < AXES; i++)
        begin
            umag0_next[i] = (in_side.len == '0) ? '0 : in_quo[i];
            usgn0_next[i] = in_side.vec.r[i][DIFF_W-1];
            u = usgn0_next[i] ? (~{1'b0, umag0_next[i]} + 1'b1) : {1'b0, umag0_next[i]};
            ep0_next[i] = {{QUO_W{1'b0}}, cfg.rest_length} * {{CFG_W{1'b0}}, umag0_next[i]};
            vu0_next[i] = VU_W'($signed({{U_W{in_side.vec.v[i][DIFF_W-1]}}, in_side.vec.v[i]})
                              * $signed({{DIFF_W{u[U_W-1]}}, u}));
        end
        brk0_next = cfg.limited_mode
                    && ({{(LIMIT_W-ROOT_W){1'b0}}, in_side.len} > cfg.limit);
    end

    // Stage 1: spring stretch and dot product.
    logic                       vld1_reg;
    logic [AXES-1:0][D_W-1:0]   d1_reg;
    logic [DOT_W-1:0]           dot1_reg;
    logic [AXES-1:0][QUO_W-1:0] umag1_reg;
    logic [AXES-1:0]            usgn1_reg;
    logic                       brk1_reg;

    logic [AXES-1:0][D_W-1:0]   d1_next;
    logic [DOT_W-1:0]           dot1_next;

    always_comb
    begin
        logic [D_W-1:0] r_ext;
        logic [D_W-1:0] e_ext;
        dot1_next = '0;
        for (int i = 0; i < AXES; i++)
        begin
            r_ext = {{(D_W-DIFF_W){r0_reg[i][DIFF_W-1]}}, r0_reg[i]};
            e_ext = {{(D_W-(EP_W-FRAC)){1'b0}}, ep0_reg[i][EP_W-1:FRAC]};
            d1_next[i] = usgn0_reg[i] ? r_ext + e_ext : r_ext - e_ext;
            dot1_next = dot1_next + {{(DOT_W-VU_W){vu0_reg[i][VU_W-1]}}, vu0_reg[i]};
        end
    end

    // Stage 2: stiffness partial products and axial speed.
    logic                       vld2_reg;
    logic [AXES-1:0][KH_W-1:0]  kh2_reg;
    logic [AXES-1:0][KL_W-1:0]  kl2_reg;
    logic [AXES-1:0]            dsgn2_reg;
    logic [S_W-1:0]             smag2_reg;
    logic                       ssgn2_reg;
    logic [AXES-1:0][QUO_W-1:0] umag2_reg;
    logic [AXES-1:0]            usgn2_reg;
    logic                       brk2_reg;

    logic [AXES-1:0][KH_W-1:0]  kh2_next;
    logic [AXES-1:0][KL_W-1:0]  kl2_next;
    logic [S_W-1:0]             smag2_next;

    always_comb
    begin
        logic [D_W-1:0]   dmag;
        logic [DOT_W-1:0] dotmag;
        for (int i = 0; i < AXES; i++)
        begin
            dmag = d1_reg[i][D_W-1] ? (~d1_reg[i] + 1'b1) : d1_reg[i];
            kh2_next[i] = {{(D_W-1-FRAC){1'b0}}, cfg.stiffness}
                          * {{CFG_W{1'b0}}, dmag[D_W-2:FRAC]};
            kl2_next[i] = {{FRAC{1'b0}}, cfg.stiffness} * {{CFG_W{1'b0}}, dmag[FRAC-1:0]};
        end
        dotmag = dot1_reg[DOT_W-1] ? (~dot1_reg + 1'b1) : dot1_reg;
        smag2_next = dotmag[DOT_W-1:FRAC];
    end

    // Stage 3: elastic magnitude and projection product.
    logic                       vld3_reg;
    logic [AXES-1:0][EL_W-1:0]  elm3_reg;
    logic [AXES-1:0]            dsgn3_reg;
    logic [AXES-1:0][PP_W-1:0]  pp3_reg;
    logic [AXES-1:0]            psgn3_reg;
    logic                       brk3_reg;

    logic [AXES-1:0][EL_W-1:0]  elm3_next;
    logic [AXES-1:0][PP_W-1:0]  pp3_next;

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            elm3_next[i] = {1'b0, kh2_reg[i]}
                           + {{(EL_W-(KL_W-FRAC)){1'b0}}, kl2_reg[i][KL_W-1:FRAC]};
            pp3_next[i] = {{QUO_W{1'b0}}, smag2_reg} * {{S_W{1'b0}}, umag2_reg[i]};
        end
    end

    // Stage 4: signed elastic term and damping partial products.
    logic                       vld4_reg;
    logic [AXES-1:0][EL_W:0]    el4_reg;
    logic [AXES-1:0][DH_W-1:0]  dh4_reg;
    logic [AXES-1:0][KL_W-1:0]  dl4_reg;
    logic [AXES-1:0]            psgn4_reg;
    logic                       brk4_reg;

    logic [AXES-1:0][EL_W:0]    el4_next;
    logic [AXES-1:0][DH_W-1:0]  dh4_next;
    logic [AXES-1:0][KL_W-1:0]  dl4_next;

    always_comb
    begin
        logic [PM_W-1:0] pmag;
        for (int i = 0; i < AXES; i++)
        begin
            pmag = pp3_reg[i][PP_W-1:FRAC];
            el4_next[i] = dsgn3_reg[i] ? (~{1'b0, elm3_reg[i]} + 1'b1) : {1'b0, elm3_reg[i]};
            dh4_next[i] = {{(PM_W-FRAC){1'b0}}, cfg.damping}
                          * {{CFG_W{1'b0}}, pmag[PM_W-1:FRAC]};
            dl4_next[i] = {{FRAC{1'b0}}, cfg.damping} * {{CFG_W{1'b0}}, pmag[FRAC-1:0]};
        end
    end

    // Stage 5: total force with saturation.
    logic                       vld5_reg;
    logic [AXES-1:0][DW-1:0]    f5_reg;
    logic                       brk5_reg;

    logic [AXES-1:0][DW-1:0]    f5_next;

    always_comb
    begin
        logic [DM_W-1:0]  dmm;
        logic [SUM_W-1:0] dm;
        logic [SUM_W-1:0] sum;
        for (int i = 0; i < AXES; i++)
        begin
            dmm = {1'b0, dh4_reg[i]} + {{(DM_W-(KL_W-FRAC)){1'b0}}, dl4_reg[i][KL_W-1:FRAC]};
            dm  = psgn4_reg[i] ? (~{1'b0, dmm} + 1'b1) : {1'b0, dmm};
            sum = {{(SUM_W-EL_W-1){el4_reg[i][EL_W]}}, el4_reg[i]} + dm;
            if (!sum[SUM_W-1] && (sum[SUM_W-2:DW-1] != '0))
            begin
                f5_next[i] = {1'b0, {(DW-1){1'b1}}};
            end
            else if (sum[SUM_W-1] && (sum[SUM_W-2:DW-1] != '1))
            begin
                f5_next[i] = {1'b1, {(DW-1){1'b0}}};
            end
            else
            begin
                f5_next[i] = sum[DW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= in_vld;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
            vld4_reg <= vld3_reg;
            vld5_reg <= vld4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg    <= in_side.vec.r;
            umag0_reg <= umag0_next;
            usgn0_reg <= usgn0_next;
            ep0_reg   <= ep0_next;
            vu0_reg   <= vu0_next;
            brk0_reg  <= brk0_next;

            d1_reg    <= d1_next;
            dot1_reg  <= dot1_next;
            umag1_reg <= umag0_reg;
            usgn1_reg <= usgn0_reg;
            brk1_reg  <= brk0_reg;

            kh2_reg   <= kh2_next;
            kl2_reg   <= kl2_next;
            for (int i = 0; i < AXES; i++)
            begin
                dsgn2_reg[i] <= d1_reg[i][D_W-1];
            end
            smag2_reg <= smag2_next;
            ssgn2_reg <= dot1_reg[DOT_W-1];
            umag2_reg <= umag1_reg;
            usgn2_reg <= usgn1_reg;
            brk2_reg  <= brk1_reg;

            elm3_reg  <= elm3_next;
            dsgn3_reg <= dsgn2_reg;
            pp3_reg   <= pp3_next;
            for (int i = 0; i < AXES; i++)
            begin
                psgn3_reg[i] <= ssgn2_reg ^ usgn2_reg[i];
            end
            brk3_reg  <= brk2_reg;

            el4_reg   <= el4_next;
            dh4_reg   <= dh4_next;
            dl4_reg   <= dl4_next;
            psgn4_reg <= psgn3_reg;
            brk4_reg  <= brk3_reg;

            f5_reg    <= f5_next;
            brk5_reg  <= brk4_reg;
        end
    end

    assign out_vld    = vld5_reg;
    assign out_force  = f5_reg;
    assign out_broken = brk5_reg;

endmodule

FILE: hw/rtl/spring_damper_bond_force_top.sv
// Spring-damper bond force unit. Each input word carries the positions and
// velocities of two bonded particles in signed Q16.16, and each output word
// returns the saturated spring plus axial damping force on the second particle
// together with the broken flag. It accepts one word every clock cycle while
// the output is not stalled and returns results in order, through the 33-stage
// bit-per-stage square root that forms the bond length and the 17-stage
// divider that forms the unit vector. When the output is stalled the whole
// pipeline holds and input ready drops. The user must write registers through
// the write port only while no word is in flight; the unit does not check.
module spring_damper_bond_force_top import spdb_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    spdb_in_if.sink          din,
    spdb_out_if.source       dout
);

    logic [CFG_W-1:0]   stiffness_reg;
    logic [CFG_W-1:0]   damping_reg;
    logic [CFG_W-1:0]   rest_length_reg;
    logic [CFG_W-1:0]   break_factor_reg;
    logic               limited_mode_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [2*CFG_W-1:0] limit_prod;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stiffness_reg    <= CFG_W'(65536);
            damping_reg      <= '0;
            rest_length_reg  <= CFG_W'(65536);
            break_factor_reg <= CFG_W'(131072);
            limited_mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_STIFFNESS:    stiffness_reg    <= cfg_data;
                REG_DAMPING:      damping_reg      <= cfg_data;
                REG_REST_LENGTH:  rest_length_reg  <= cfg_data;
                REG_BREAK_FACTOR: break_factor_reg <= cfg_data;
                REG_LIMITED_MODE: limited_mode_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    assign limit_prod = {{CFG_W{1'b0}}, break_factor_reg} * {{CFG_W{1'b0}}, rest_length_reg};

    always_ff @(posedge clk)
    begin
        limit_reg <= limit_prod[2*CFG_W-1:FRAC];
    end

    logic en;
    logic fo_vld;

    assign en        = !fo_vld || dout.ready;
    assign din.ready = en;

    // Stage 0: differences.
    logic [AXES-1:0][DW-1:0] pa;
    logic [AXES-1:0][DW-1:0] pb;
    logic [AXES-1:0][DW-1:0] va;
    logic [AXES-1:0][DW-1:0] vb;
    bond_vec_t               vec0_next;

    assign pa = {din.pos_a_z, din.pos_a_y, din.pos_a_x};
    assign pb = {din.pos_b_z, din.pos_b_y, din.pos_b_x};
    assign va = {din.vel_a_z, din.vel_a_y, din.vel_a_x};
    assign vb = {din.vel_b_z, din.vel_b_y, din.vel_b_x};

    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            vec0_next.r[i] = {pa[i][DW-1], pa[i]} - {pb[i][DW-1], pb[i]};
            vec0_next.v[i] = {va[i][DW-1], va[i]} - {vb[i][DW-1], vb[i]};
        end
    end

    logic      vld0_reg;
    bond_vec_t vec0_reg;

    // Stage 1: squares.
    logic [AXES-1:0][SQ_W-1:0] sq1_next;
    logic                      vld1_reg;
    logic [AXES-1:0][SQ_W-1:0] sq1_reg;
    bond_vec_t                 vec1_reg;

    always_comb
    begin
        logic [DIFF_W-1:0] rm;
        for (int i = 0; i < AXES; i++)
        begin
            rm = vec0_reg.r[i][DIFF_W-1] ? (~vec0_reg.r[i] + 1'b1) : vec0_reg.r[i];
            sq1_next[i] = {{DW{1'b0}}, rm[DW-1:0]} * {{DW{1'b0}}, rm[DW-1:0]};
        end
    end

    // Stage 2: sum of squares.
    logic           vld2_reg;
    logic [Q_W-1:0] q2_reg;
    logic [Q_W-1:0] q2_next;
    bond_vec_t      vec2_reg;

    assign q2_next = {2'b00, sq1_reg[0]} + {2'b00, sq1_reg[1]} + {2'b00, sq1_reg[2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld0_reg <= 1'b0;
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (en)
        begin
            vld0_reg <= din.valid;
            vld1_reg <= vld0_reg;
            vld2_reg <= vld1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec0_reg <= vec0_next;
            sq1_reg  <= sq1_next;
            vec1_reg <= vec0_reg;
            q2_reg   <= q2_next;
            vec2_reg <= vec1_reg;
        end
    end

    logic              sq_vld;
    logic [ROOT_W-1:0] sq_root;
    bond_vec_t         sq_vec;

    spdb_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (vld2_reg),
        .in_sq    (q2_reg),
        .in_vec   (vec2_reg),
        .out_vld  (sq_vld),
        .out_root (sq_root),
        .out_vec  (sq_vec)
    );

    logic [AXES-1:0][DW-1:0]    rabs;
    div_side_t                  dv_side_in;
    logic                       dv_vld;
    logic [AXES-1:0][QUO_W-1:0] dv_quo;
    div_side_t                  dv_side;

    always_comb
    begin
        logic [DIFF_W-1:0] rm;
        for (int i = 0; i < AXES; i++)
        begin
            rm = sq_vec.r[i][DIFF_W-1] ? (~sq_vec.r[i] + 1'b1) : sq_vec.r[i];
            rabs[i] = rm[DW-1:0];
        end
        dv_side_in.vec = sq_vec;
        dv_side_in.len = sq_root;
    end

    spdb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (sq_vld),
        .in_mag   (rabs),
        .in_side  (dv_side_in),
        .out_vld  (dv_vld),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    force_cfg_t              fcfg;
    logic [AXES-1:0][DW-1:0] fo_force;
    logic                    fo_broken;

    assign fcfg.stiffness    = stiffness_reg;
    assign fcfg.damping      = damping_reg;
    assign fcfg.rest_length  = rest_length_reg;
    assign fcfg.limited_mode = limited_mode_reg;
    assign fcfg.limit        = limit_reg;

    spdb_force u_force (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (fcfg),
        .in_vld     (dv_vld),
        .in_quo     (dv_quo),
        .in_side    (dv_side),
        .out_vld    (fo_vld),
        .out_force  (fo_force),
        .out_broken (fo_broken)
    );

    assign dout.valid   = fo_vld;
    assign dout.force_x = fo_force[0];
    assign dout.force_y = fo_force[1];
    assign dout.force_z = fo_force[2];
    assign dout.broken  = fo_broken;

endmodule
